### src/lzwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared constants and types for the variable width lzw compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int DICT_ENTRIES_DEF  = 4096;
    localparam int CODE_EOF          = 257;
    localparam int CODE_FIRST        = 258;
    localparam int START_WIDTH       = 9;
    localparam int WIDTH_W           = 5;
    localparam int HASH_SHIFT        = 4;
    localparam int HASH_W            = 17;

    typedef struct packed {
        logic last_code;
        logic flush;
    } cmd_flags_t;

endpackage

### src/lzwc_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_packer
// Packs variable width codes msb first into words, with an output register.
// ----------------------------------------------------------------------------
module lzwc_packer #(
    parameter int MAX_CODE_BITS = 12,
    parameter int CODE_W        = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [CODE_W-1:0]             cmd_code,
    input  logic [lzwc_pkg::WIDTH_W-1:0]  cmd_width,
    input  lzwc_pkg::cmd_flags_t          cmd_flags,
    output logic [7:0]                    m_out_byte,
    output logic                          m_run_last,
    output logic                          m_stream_done,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import lzwc_pkg::*;

    localparam int AW    = MAX_CODE_BITS + 7;
    localparam int CNT_W = $clog2(MAX_CODE_BITS + 8);

    logic [AW-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             flush_reg, flush_next;
    logic [7:0]       byte_reg, byte_next;
    logic             rl_reg, rl_next;
    logic             sd_reg, sd_next;
    logic             mv_reg, mv_next;

    logic             slot_free;
    logic             cmd_fire;
    logic [AW-1:0]    code_ext;
    logic [AW-1:0]    code_mask;
    logic [AW-1:0]    hi_shift;
    logic [AW-1:0]    pad_shift;
    logic [CNT_W-1:0] rem;

    assign slot_free = !mv_reg || m_ready;
    assign cmd_ready = (cnt_reg < CNT_W'(8)) && !(flush_reg && cnt_reg != '0);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign code_mask = ~({AW{1'b1}} << cmd_width);
    assign code_ext  = AW'(cmd_code) & code_mask;
    assign rem       = cnt_reg - CNT_W'(8);
    assign hi_shift  = acc_reg >> rem;
    assign pad_shift = acc_reg << (CNT_W'(8) - cnt_reg);

    always_comb begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        flush_next = flush_reg;
        byte_next  = byte_reg;
        rl_next    = rl_reg;
        sd_next    = sd_reg;
        mv_next    = mv_reg && !m_ready;
        if (cmd_fire) begin
            acc_next   = (acc_reg << cmd_width) | code_ext;
            cnt_next   = cnt_reg + CNT_W'(cmd_width);
            last_next  = cmd_flags.last_code;
            flush_next = cmd_flags.flush;
        end else if (slot_free) begin
            if (cnt_reg >= CNT_W'(8)) begin
                byte_next = hi_shift[7:0];
                cnt_next  = rem;
                rl_next   = last_reg && (rem < CNT_W'(8)) && !(flush_reg && rem != '0);
                sd_next   = rl_next && flush_reg;
                mv_next   = 1'b1;
                if (rl_next && flush_reg) begin
                    flush_next = 1'b0;
                end
            end else if (flush_reg && cnt_reg != '0) begin
                byte_next  = pad_shift[7:0];
                cnt_next   = '0;
                rl_next    = 1'b1;
                sd_next    = 1'b1;
                mv_next    = 1'b1;
                flush_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            flush_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            flush_reg <= flush_next;
            mv_reg    <= mv_next;
        end
        acc_reg  <= acc_next;
        byte_reg <= byte_next;
        rl_reg   <= rl_next;
        sd_reg   <= sd_next;
    end

    assign m_out_byte    = byte_reg;
    assign m_run_last    = rl_reg;
    assign m_stream_done = sd_reg;
    assign m_valid       = mv_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_CODE_BITS + 7))
        else $error("packer bit count overflow");
    a_load_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_fire |-> cnt_reg < CNT_W'(8))
        else $error("code loaded before drain");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_done) |-> m_run_last)
        else $error("stream end word not marked last");
`endif

endmodule

### src/lzwc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwc_engine
// Hash table and dictionary memories with the lookup and insert sequencer.
// ----------------------------------------------------------------------------
module lzwc_engine #(
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_ENTRIES  = 4096,
    parameter int CODE_W        = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_stream_end,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output logic [CODE_W-1:0]             cmd_code,
    output logic [lzwc_pkg::WIDTH_W-1:0]  cmd_width,
    output lzwc_pkg::cmd_flags_t          cmd_flags
);
    import lzwc_pkg::*;

    localparam int SLOTS   = 2 * DICT_ENTRIES;
    localparam int SLOT_AW = $clog2(SLOTS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SLOT  = 7'b0000100,
        S_DICT  = 7'b0001000,
        S_EMIT1 = 7'b0010000,
        S_EMIT2 = 7'b0100000,
        S_EMIT3 = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CODE_W-1:0]    prefix_reg, prefix_next;
    logic                 pvalid_reg, pvalid_next;
    logic [CODE_W:0]      nfc_reg, nfc_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [7:0]           ch_reg, ch_next;
    logic                 last_reg, last_next;
    logic [SLOT_AW-1:0]   h_reg, h_next;
    logic [CODE_W-1:0]    mcode_reg, mcode_next;
    logic [WIDTH_W-1:0]   mw_reg, mw_next;
    logic [SLOT_AW-1:0]   clr_reg, clr_next;

    logic [CODE_W:0]      slot_mem [SLOTS];
    logic [CODE_W+7:0]    dict_mem [DICT_ENTRIES];
    logic [CODE_W:0]      slot_q;
    logic [CODE_W+7:0]    dict_q;

    logic                 slot_we, dict_we;
    logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;
    logic [CODE_W:0]      slot_wdata;
    logic [HASH_W-1:0]    hash_full;
    logic                 room;
    logic                 insert;
    logic [CODE_W:0]      nfc_inc;
    logic                 accept;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign hash_full = HASH_W'(prefix_reg) | (HASH_W'(s_in_byte) << HASH_SHIFT);
    assign room      = nfc_reg < (CODE_W+1)'(DICT_ENTRIES);
    assign insert    = (state_reg == S_SLOT) && !slot_q[CODE_W] && room;
    assign nfc_inc   = nfc_reg + 1'b1;

    assign slot_raddr = (state_reg == S_IDLE) ? hash_full[SLOT_AW-1:0] : h_reg + 1'b1;
    assign slot_we    = (state_reg == S_CLEAR) || insert;
    assign slot_waddr = (state_reg == S_CLEAR) ? clr_reg : h_reg;
    assign slot_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, nfc_reg[CODE_W-1:0]};
    assign dict_we    = insert;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dict_we) begin
            dict_mem[nfc_reg[CODE_W-1:0]] <= {prefix_reg, ch_reg};
        end
        dict_q <= dict_mem[slot_q[CODE_W-1:0]];
    end

    always_comb begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        pvalid_next = pvalid_reg;
        nfc_next    = nfc_reg;
        width_next  = width_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        h_next      = h_reg;
        mcode_next  = mcode_reg;
        mw_next     = mw_reg;
        clr_next    = clr_reg;
        cmd_valid   = 1'b0;
        cmd_code    = prefix_reg;
        cmd_width   = width_reg;
        cmd_flags   = '0;
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {SLOT_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    ch_next   = s_in_byte;
                    last_next = s_stream_end;
                    if (!pvalid_reg) begin
                        prefix_next = CODE_W'(s_in_byte);
                        pvalid_next = 1'b1;
                        if (s_stream_end) begin
                            state_next = S_EMIT2;
                        end
                    end else begin
                        h_next     = hash_full[SLOT_AW-1:0];
                        state_next = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                if (slot_q[CODE_W]) begin
                    mcode_next = slot_q[CODE_W-1:0];
                    state_next = S_DICT;
                end else begin
                    mcode_next  = prefix_reg;
                    mw_next     = width_reg;
                    prefix_next = CODE_W'(ch_reg);
                    if (room) begin
                        nfc_next = nfc_inc;
                        if (width_reg < WIDTH_W'(MAX_CODE_BITS) &&
                            nfc_inc == ((CODE_W+1)'(1) << width_reg)) begin
                            width_next = width_reg + 1'b1;
                        end
                    end
                    state_next = S_EMIT1;
                end
            end
            S_DICT: begin
                if (dict_q == {prefix_reg, ch_reg}) begin
                    prefix_next = mcode_reg;
                    state_next  = last_reg ? S_EMIT2 : S_IDLE;
                end else begin
                    h_next     = h_reg + 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_EMIT1: begin
                cmd_valid           = 1'b1;
                cmd_code            = mcode_reg;
                cmd_width           = mw_reg;
                cmd_flags.last_code = !last_reg;
                if (cmd_ready) begin
                    state_next = last_reg ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                cmd_valid = 1'b1;
                if (cmd_ready) begin
                    state_next = S_EMIT3;
                end
            end
            S_EMIT3: begin
                cmd_valid           = 1'b1;
                cmd_code            = CODE_W'(CODE_EOF);
                cmd_flags.last_code = 1'b1;
                cmd_flags.flush     = 1'b1;
                if (cmd_ready) begin
                    prefix_next = '0;
                    pvalid_next = 1'b0;
                    nfc_next    = (CODE_W+1)'(CODE_FIRST);
                    width_next  = WIDTH_W'(START_WIDTH);
                    clr_next    = '0;
                    state_next  = S_CLEAR;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            prefix_reg <= '0;
            pvalid_reg <= 1'b0;
            nfc_reg    <= (CODE_W+1)'(CODE_FIRST);
            width_reg  <= WIDTH_W'(START_WIDTH);
            clr_reg    <= '0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            pvalid_reg <= pvalid_next;
            nfc_reg    <= nfc_next;
            width_reg  <= width_next;
            clr_reg    <= clr_next;
            last_reg   <= last_next;
        end
        ch_reg    <= ch_next;
        h_reg     <= h_next;
        mcode_reg <= mcode_next;
        mw_reg    <= mw_next;
    end

`ifndef NO_ASSERTIONS
    a_nfc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nfc_reg <= (CODE_W+1)'(DICT_ENTRIES))
        else $error("code counter past dictionary size");
    a_width_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        width_reg >= WIDTH_W'(START_WIDTH) && width_reg <= WIDTH_W'(MAX_CODE_BITS))
        else $error("code width out of range");
    a_insert_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        dict_we |-> (state_reg == S_SLOT) && !slot_q[CODE_W])
        else $error("insert into used slot");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("item accepted during table clear");
`endif

endmodule

### src/lzw_variable_width_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_variable_width_compressor
// LZW compressor, 9 to MAX_CODE_BITS bit codes packed msb first into words.
// ----------------------------------------------------------------------------
// One input word is taken at a time. A byte that extends the prefix is
// accepted, then each hash probe reads the hash slot and then the dictionary
// entry; a miss adds an emit step that hands the code to the bit packer,
// which drains one output word per cycle behind its own output register
// while m_ready is high. After reset and after every stream end the hash
// table of 2*DICT_ENTRIES slots (8192 by default) is swept clear, one slot a
// cycle, during which no input is taken.
module lzw_variable_width_compressor #(
    parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
    parameter int DICT_ENTRIES  = lzwc_pkg::DICT_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_in_byte,
    input  logic       s_stream_end,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_stream_done,
    output logic       m_valid,
    input  logic       m_ready
);
    import lzwc_pkg::*;

    localparam int CODE_W = $clog2(DICT_ENTRIES);

    logic               cmd_valid;
    logic               cmd_ready;
    logic [CODE_W-1:0]  cmd_code;
    logic [WIDTH_W-1:0] cmd_width;
    cmd_flags_t         cmd_flags;

    lzwc_engine #(
        .MAX_CODE_BITS(MAX_CODE_BITS),
        .DICT_ENTRIES (DICT_ENTRIES),
        .CODE_W       (CODE_W)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_in_byte   (s_in_byte),
        .s_stream_end(s_stream_end),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_code    (cmd_code),
        .cmd_width   (cmd_width),
        .cmd_flags   (cmd_flags)
    );

    lzwc_packer #(
        .MAX_CODE_BITS(MAX_CODE_BITS),
        .CODE_W       (CODE_W)
    ) u_packer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd_code     (cmd_code),
        .cmd_width    (cmd_width),
        .cmd_flags    (cmd_flags),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_stream_done(m_stream_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule
